// ===== hw/rtl/mtc_pkg.sv =====
// ----------------------------------------------------------------------------
// mtc_pkg
// Shared types, character codes and the Morse code table of the text codec.
// ----------------------------------------------------------------------------
package mtc_pkg;

  // Longest decodable symbol run; longer runs decode to byte 0.
  localparam int MAX_CODE_LEN = 5;
  localparam int CNT_W        = $clog2(MAX_CODE_LEN + 2);
  // Longest code in the table.
  localparam int CODE_W       = 5;
  localparam int LEN_W        = 3;
  localparam int NUM_CODES    = 36;
  localparam int IDX_W        = 6;

  localparam int FIFO_DEPTH   = 4;
  localparam int FIFO_AW      = $clog2(FIFO_DEPTH);

  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_DASH  = 8'h2D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_UA    = 8'h41;
  localparam logic [7:0] CH_UZ    = 8'h5A;
  localparam logic [7:0] CH_LA    = 8'h61;
  localparam logic [7:0] CH_LZ    = 8'h7A;
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_1     = 8'h31;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] CASE_OFS = 8'h20;

  // One table entry: symbol count and symbols, first symbol in the highest
  // used bit, 1 = dash.
  typedef struct packed {
    logic [LEN_W-1:0]  len;
    logic [CODE_W-1:0] pat;
  } code_t;

  // Work for the output serializer; emitted in field order, each part
  // only where present.
  typedef struct packed {
    logic [LEN_W-1:0]  sym_cnt;
    logic [CODE_W-1:0] sym_pat;   // left aligned, next symbol in the top bit
    logic              sp1;
    logic              sp2;
    logic              chr_vld;
    logic [7:0]        chr;
    logic              err;
    logic              nl;
  } job_t;

  typedef struct packed {
    logic full;
    logic not_empty;
  } fifo_stat_t;

  function automatic code_t code_lookup(input logic [IDX_W-1:0] idx);
    code_t e;
    unique case (idx)
      6'd0:  e = {3'd2, 5'b00001};
      6'd1:  e = {3'd4, 5'b01000};
      6'd2:  e = {3'd4, 5'b01010};
      6'd3:  e = {3'd3, 5'b00100};
      6'd4:  e = {3'd1, 5'b00000};
      6'd5:  e = {3'd4, 5'b00010};
      6'd6:  e = {3'd3, 5'b00110};
      6'd7:  e = {3'd4, 5'b00000};
      6'd8:  e = {3'd2, 5'b00000};
      6'd9:  e = {3'd4, 5'b00111};
      6'd10: e = {3'd3, 5'b00101};
      6'd11: e = {3'd4, 5'b00100};
      6'd12: e = {3'd2, 5'b00011};
      6'd13: e = {3'd2, 5'b00010};
      6'd14: e = {3'd3, 5'b00111};
      6'd15: e = {3'd4, 5'b00110};
      6'd16: e = {3'd4, 5'b01101};
      6'd17: e = {3'd3, 5'b00010};
      6'd18: e = {3'd3, 5'b00000};
      6'd19: e = {3'd1, 5'b00001};
      6'd20: e = {3'd3, 5'b00001};
      6'd21: e = {3'd4, 5'b00001};
      6'd22: e = {3'd3, 5'b00011};
      6'd23: e = {3'd4, 5'b01001};
      6'd24: e = {3'd4, 5'b01011};
      6'd25: e = {3'd4, 5'b01100};
      6'd26: e = {3'd5, 5'b01111};
      6'd27: e = {3'd5, 5'b00111};
      6'd28: e = {3'd5, 5'b00011};
      6'd29: e = {3'd5, 5'b00001};
      6'd30: e = {3'd5, 5'b00000};
      6'd31: e = {3'd5, 5'b10000};
      6'd32: e = {3'd5, 5'b11000};
      6'd33: e = {3'd5, 5'b11100};
      6'd34: e = {3'd5, 5'b11110};
      6'd35: e = {3'd5, 5'b11111};
      default: e = '0;
    endcase
    return e;
  endfunction

  // Character for a table index, letters in the case asked for.
  function automatic logic [7:0] code_char(input logic [IDX_W-1:0] idx,
                                           input logic upper);
    logic [7:0] c;
    if (idx < IDX_W'(26)) begin
      c = CH_UA + 8'(idx);
      if (!upper) c = c + CASE_OFS;
    end else if (idx < IDX_W'(NUM_CODES - 1)) begin
      c = CH_1 + 8'(idx) - 8'd26;
    end else begin
      c = CH_0;
    end
    return c;
  endfunction

  // {valid, table index} of a letter or digit.
  function automatic logic [IDX_W:0] char_index(input logic [7:0] c);
    logic [7:0] d;
    logic       vld;
    d   = '0;
    vld = 1'b1;
    if (c >= CH_UA && c <= CH_UZ) begin
      d = c - CH_UA;
    end else if (c >= CH_LA && c <= CH_LZ) begin
      d = c - CH_LA;
    end else if (c >= CH_1 && c <= CH_9) begin
      d = c - CH_1 + 8'd26;
    end else if (c == CH_0) begin
      d = 8'(NUM_CODES - 1);
    end else begin
      vld = 1'b0;
    end
    return {vld, d[IDX_W-1:0]};
  endfunction

  // Character for a gathered symbol run, or byte 0 when nothing matches.
  function automatic logic [7:0] decode_code(input logic [CNT_W-1:0] cnt,
                                             input logic [MAX_CODE_LEN-1:0] pat,
                                             input logic upper);
    logic [7:0] res;
    code_t      e;
    res = CH_NUL;
    if (cnt <= CNT_W'(MAX_CODE_LEN)) begin
      for (int i = 0; i < NUM_CODES; i++) begin
        e = code_lookup(IDX_W'(i));
        if (32'(e.len) == 32'(cnt) && 32'(e.pat) == 32'(pat)) begin
          res = code_char(IDX_W'(i), upper);
        end
      end
    end
    return res;
  endfunction

  function automatic logic job_left(input job_t j);
    return (j.sym_cnt != '0) || j.sp1 || j.sp2 || j.chr_vld || j.nl;
  endfunction

endpackage

// ===== hw/rtl/mtc_front.sv =====
// ----------------------------------------------------------------------------
// mtc_front
// Accepts characters, tracks the word mode and symbol register, and turns
// each encoded character, decoded word end or error into a serializer job.
// ----------------------------------------------------------------------------
module mtc_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [7:0]          in_char_in,
  input  logic                in_word_last,
  input  logic                in_line_last,
  input  logic                cfg_valid,
  input  logic                cfg_upper_case,
  input  mtc_pkg::fifo_stat_t fifo_stat,
  output logic                push,
  output mtc_pkg::job_t       push_job
);
  import mtc_pkg::*;

  localparam logic [1:0] MODE_START = 2'd0;
  localparam logic [1:0] MODE_ENC   = 2'd1;
  localparam logic [1:0] MODE_DEC   = 2'd2;
  localparam logic [1:0] MODE_DROP  = 2'd3;

  logic [1:0]              mode_r, mode_nxt;
  logic [CNT_W-1:0]        cnt_r, cnt_nxt;
  logic [MAX_CODE_LEN-1:0] pat_r, pat_nxt;
  logic                    upper_r;

  logic                    accept;
  logic                    word_end;
  logic [IDX_W:0]          cidx;
  logic                    is_alnum;
  logic                    is_sym;
  logic [1:0]              eff_mode;
  code_t                   code;
  logic [CNT_W-1:0]        dcnt;
  logic [MAX_CODE_LEN-1:0] dpat;

  assign in_stall = fifo_stat.full;
  assign accept   = in_valid && !in_stall;
  assign word_end = in_word_last || in_line_last;
  assign cidx     = char_index(in_char_in);
  assign is_alnum = cidx[IDX_W];
  assign is_sym   = (in_char_in == CH_DOT) || (in_char_in == CH_DASH);
  assign code     = code_lookup(cidx[IDX_W-1:0]);

  // Symbol register after taking this character; it saturates one past
  // the longest code so that overlong runs decode to byte 0.
  always_comb begin
    if (cnt_r < CNT_W'(MAX_CODE_LEN)) begin
      dpat = {pat_r[MAX_CODE_LEN-2:0], in_char_in == CH_DASH};
      dcnt = cnt_r + CNT_W'(1);
    end else begin
      dpat = pat_r;
      dcnt = CNT_W'(MAX_CODE_LEN + 1);
    end
  end

  always_comb begin
    if (mode_r == MODE_START) begin
      eff_mode = is_alnum ? MODE_ENC : (is_sym ? MODE_DEC : MODE_START);
    end else begin
      eff_mode = mode_r;
    end
  end

  always_comb begin
    mode_nxt = mode_r;
    cnt_nxt  = cnt_r;
    pat_nxt  = pat_r;
    push     = 1'b0;
    push_job = '0;
    if (accept) begin
      if (mode_r == MODE_DROP) begin
        if (in_line_last) mode_nxt = MODE_START;
      end else if (eff_mode == MODE_ENC && is_alnum) begin
        push             = 1'b1;
        push_job.sym_cnt = code.len;
        push_job.sym_pat = code.pat << (LEN_W'(CODE_W) - code.len);
        push_job.sp1     = 1'b1;
        push_job.sp2     = word_end;
        push_job.nl      = in_line_last;
        mode_nxt         = word_end ? MODE_START : MODE_ENC;
      end else if (eff_mode == MODE_DEC && is_sym) begin
        if (word_end) begin
          push             = 1'b1;
          push_job.chr_vld = 1'b1;
          push_job.chr     = decode_code(dcnt, dpat, upper_r);
          push_job.nl      = in_line_last;
          cnt_nxt          = '0;
          pat_nxt          = '0;
          mode_nxt         = MODE_START;
        end else begin
          cnt_nxt  = dcnt;
          pat_nxt  = dpat;
          mode_nxt = MODE_DEC;
        end
      end else begin
        // Class break: one error result, then the line is dropped.
        push             = 1'b1;
        push_job.chr_vld = 1'b1;
        push_job.chr     = CH_NUL;
        push_job.err     = 1'b1;
        cnt_nxt          = '0;
        pat_nxt          = '0;
        mode_nxt         = in_line_last ? MODE_START : MODE_DROP;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= MODE_START;
      cnt_r   <= '0;
      pat_r   <= '0;
      upper_r <= 1'b0;
    end else begin
      mode_r <= mode_nxt;
      cnt_r  <= cnt_nxt;
      pat_r  <= pat_nxt;
      if (cfg_valid) upper_r <= cfg_upper_case;
    end
  end

`ifndef NO_ASSERTIONS
  a_dec_has_symbols: assert property (@(posedge clk) disable iff (!rst_n)
    mode_r == MODE_DEC |-> cnt_r != '0)
    else $error("decode mode with an empty symbol register");

  a_idle_reg_clear: assert property (@(posedge clk) disable iff (!rst_n)
    mode_r != MODE_DEC |-> (cnt_r == '0 && pat_r == '0))
    else $error("symbol register not cleared outside decode mode");

  a_no_push_when_dropping: assert property (@(posedge clk) disable iff (!rst_n)
    mode_r == MODE_DROP |-> !push)
    else $error("job pushed while dropping the line");
`endif

endmodule

// ===== hw/rtl/mtc_job_fifo.sv =====
// ----------------------------------------------------------------------------
// mtc_job_fifo
// Short queue of serializer jobs between the front and the back.
// ----------------------------------------------------------------------------
module mtc_job_fifo (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  mtc_pkg::job_t       push_job,
  input  logic                pop,
  output mtc_pkg::job_t       head_job,
  output mtc_pkg::fifo_stat_t stat
);
  import mtc_pkg::*;

  job_t                 mem [FIFO_DEPTH];
  logic [FIFO_AW-1:0]   wr_ptr_r;
  logic [FIFO_AW-1:0]   rd_ptr_r;
  logic [FIFO_AW:0]     cnt_r;
  logic [FIFO_AW:0]     cnt_nxt;

  assign head_job       = mem[rd_ptr_r];
  assign stat.full      = (cnt_r == (FIFO_AW + 1)'(FIFO_DEPTH));
  assign stat.not_empty = (cnt_r != '0);

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) cnt_nxt = cnt_r + (FIFO_AW + 1)'(1);
    if (pop && !push) cnt_nxt = cnt_r - (FIFO_AW + 1)'(1);
  end

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr_r] <= push_job;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + FIFO_AW'(1);
      if (pop)  rd_ptr_r <= rd_ptr_r + FIFO_AW'(1);
      cnt_r <= cnt_nxt;
    end
  end

`ifndef NO_ASSERTIONS
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> (!stat.full || pop))
    else $error("job queue overflow");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> stat.not_empty)
    else $error("job queue underflow");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= (FIFO_AW + 1)'(FIFO_DEPTH))
    else $error("job queue count out of range");
`endif

endmodule

// ===== hw/rtl/mtc_back.sv =====
// ----------------------------------------------------------------------------
// mtc_back
// Output serializer: walks one job at a time and sends one result per word
// through a registered output stage.
// ----------------------------------------------------------------------------
module mtc_back (
  input  logic                clk,
  input  logic                rst_n,
  input  mtc_pkg::job_t       head_job,
  input  mtc_pkg::fifo_stat_t fifo_stat,
  output logic                pop,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [7:0]          out_char_out,
  output logic                out_is_error,
  output logic                out_last
);
  import mtc_pkg::*;

  job_t       cur_r, cur_nxt;
  logic       busy_r, busy_nxt;
  logic       out_valid_r;
  logic [7:0] out_char_r;
  logic       out_err_r;
  logic       out_last_r;

  job_t       rest;
  logic [7:0] emit_char;
  logic       emit_err;
  logic       emit_last;
  logic       emit;

  // Next result of the current job and what is left after it.
  always_comb begin
    rest      = cur_r;
    emit_char = CH_NUL;
    emit_err  = 1'b0;
    if (cur_r.sym_cnt != '0) begin
      emit_char     = cur_r.sym_pat[CODE_W-1] ? CH_DASH : CH_DOT;
      rest.sym_pat  = cur_r.sym_pat << 1;
      rest.sym_cnt  = cur_r.sym_cnt - LEN_W'(1);
    end else if (cur_r.sp1) begin
      emit_char = CH_SPACE;
      rest.sp1  = 1'b0;
    end else if (cur_r.sp2) begin
      emit_char = CH_SPACE;
      rest.sp2  = 1'b0;
    end else if (cur_r.chr_vld) begin
      emit_char    = cur_r.chr;
      emit_err     = cur_r.err;
      rest.chr_vld = 1'b0;
    end else begin
      emit_char = CH_NL;
      rest.nl   = 1'b0;
    end
    emit_last = !job_left(rest);
  end

  assign emit = busy_r && (!out_valid_r || !out_stall);
  assign pop  = fifo_stat.not_empty && (!busy_r || (emit && emit_last));

  always_comb begin
    busy_nxt = busy_r;
    cur_nxt  = cur_r;
    if (pop) begin
      busy_nxt = 1'b1;
      cur_nxt  = head_job;
    end else if (emit) begin
      busy_nxt = !emit_last;
      cur_nxt  = rest;
    end
  end

  always_ff @(posedge clk) begin
    cur_r <= cur_nxt;
    if (emit) begin
      out_char_r <= emit_char;
      out_err_r  <= emit_err;
      out_last_r <= emit_last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid    = out_valid_r;
  assign out_char_out = out_char_r;
  assign out_is_error = out_err_r;
  assign out_last     = out_last_r;

`ifndef NO_ASSERTIONS
  a_busy_has_work: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> job_left(cur_r))
    else $error("serializer busy on an empty job");

  a_error_is_lone: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_err_r |-> (out_char_r == CH_NUL && out_last_r))
    else $error("error result not alone or not zero");

  a_out_held: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_stall |=> out_valid_r && $stable({out_char_r, out_err_r, out_last_r}))
    else $error("stalled result changed");
`endif

endmodule

// ===== hw/rtl/morse_text_codec.sv =====
// ----------------------------------------------------------------------------
// morse_text_codec
// Morse code encoder and decoder for a text line, one character per word.
// ----------------------------------------------------------------------------
// Input channel (in_valid / in_stall): one character with word and line end
// flags per word. Letters and digits are encoded to dots, dashes and spaces;
// a word of dots and dashes is decoded to one character at its end. A line
// end adds a newline unless an error broke the line. A character breaking
// its word's class gives one error result; the rest of the line is dropped.
// Result channel (out_valid / out_stall): one output character per word,
// out_last marks the final result of an input character. Some inputs give
// no result at all.
// Config channel (cfg_valid / cfg_ready): cfg_upper_case selects the case of
// decoded letters. cfg_ready is always high; write only while idle.
// A character's job goes through the job queue, the serializer's job
// register and the output register. The serializer sends one result per
// cycle while the receiver does not stall; a character makes up to 8
// results, and a four-entry job queue lets the input run ahead and
// stalls the input when it is full.
// Reset clears the word mode, symbol register, queue and output stage, and
// sets lower case. A stalled receiver holds the output register and, once
// the queue fills, stalls the input.
module morse_text_codec (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_char_in,
  input  logic       in_word_last,
  input  logic       in_line_last,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_char_out,
  output logic       out_is_error,
  output logic       out_last,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic       cfg_upper_case
);
  import mtc_pkg::*;

  fifo_stat_t fifo_stat;
  logic       push;
  job_t       push_job;
  logic       pop;
  job_t       head_job;

  assign cfg_ready = 1'b1;

  mtc_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_char_in     (in_char_in),
    .in_word_last   (in_word_last),
    .in_line_last   (in_line_last),
    .cfg_valid      (cfg_valid),
    .cfg_upper_case (cfg_upper_case),
    .fifo_stat      (fifo_stat),
    .push           (push),
    .push_job       (push_job)
  );

  mtc_job_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .head_job (head_job),
    .stat     (fifo_stat)
  );

  mtc_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .head_job     (head_job),
    .fifo_stat    (fifo_stat),
    .pop          (pop),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_char_out (out_char_out),
    .out_is_error (out_is_error),
    .out_last     (out_last)
  );

endmodule

// ===== sim/morse_text_codec_tb.sv =====
// ----------------------------------------------------------------------------
// morse_text_codec_tb
// Self-checking bench for the Morse text encoder and decoder. Whole text
// lines are queued as character words, and a behavioral model predicts every
// emitted character. Both channels idle at random, the receiver once holds
// off long enough to back up the input, and the letter case is switched
// between phases.
// ----------------------------------------------------------------------------
module morse_text_codec_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import mtc_pkg::*;

  typedef enum logic [1:0] {WORD_IDLE, WORD_ENCODE, WORD_DECODE, LINE_DROP} line_state_t;

  typedef struct packed {
    logic [7:0] ch;
    logic       word_end;
    logic       line_end;
    logic       drain;      // not a character: hold the sender until all is out
  } text_char_t;

  typedef struct packed {
    logic [7:0] ch;
    logic       err;
    logic       last;
  } morse_out_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [7:0] in_char_in = '0;
  logic       in_word_last = 1'b0;
  logic       in_line_last = 1'b0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [7:0] out_char_out;
  logic       out_is_error;
  logic       out_last;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic       cfg_upper_case = 1'b0;

  text_char_t pending_chars[$];
  morse_out_t expected_chars[$];
  text_char_t cur_char;

  // Model of the codec state.
  line_state_t             line_state;
  logic [2:0]              sym_count;
  logic [MAX_CODE_LEN-1:0] sym_bits;
  logic                    upper_sel = 1'b0;

  int          chars_taken = 0;
  int          mismatches = 0;
  int          gap_left = 0;
  int          stall_left = 0;
  bit          draining = 1'b0;
  logic        calm = 1'b0;
  logic        hold_arm = 1'b0;
  int unsigned hold_left = 0;

  morse_text_codec dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_char_in     (in_char_in),
    .in_word_last   (in_word_last),
    .in_line_last   (in_line_last),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_char_out   (out_char_out),
    .out_is_error   (out_is_error),
    .out_last       (out_last),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_upper_case (cfg_upper_case)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #3_000_000;
    $display("FAIL");
    $finish;
  end

  // International Morse code, letters A to Z and then digits 1 to 9 and 0.
  function automatic string morse_code(int idx);
    case (idx)
      0:  return ".-";
      1:  return "-...";
      2:  return "-.-.";
      3:  return "-..";
      4:  return ".";
      5:  return "..-.";
      6:  return "--.";
      7:  return "....";
      8:  return "..";
      9:  return ".---";
      10: return "-.-";
      11: return ".-..";
      12: return "--";
      13: return "-.";
      14: return "---";
      15: return ".--.";
      16: return "--.-";
      17: return ".-.";
      18: return "...";
      19: return "-";
      20: return "..-";
      21: return "...-";
      22: return ".--";
      23: return "-..-";
      24: return "-.--";
      25: return "--..";
      26: return ".----";
      27: return "..---";
      28: return "...--";
      29: return "....-";
      30: return ".....";
      31: return "-....";
      32: return "--...";
      33: return "---..";
      34: return "----.";
      default: return "-----";
    endcase
  endfunction

  function automatic int alnum_index(logic [7:0] c);
    if (c >= CH_UA && c <= CH_UZ) return int'(c - CH_UA);
    if (c >= CH_LA && c <= CH_LZ) return int'(c - CH_LA);
    if (c >= CH_1 && c <= CH_9) return int'(c - CH_1) + 26;
    if (c == CH_0) return 35;
    return -1;
  endfunction

  function automatic bit is_symbol(logic [7:0] c);
    return c == CH_DOT || c == CH_DASH;
  endfunction

  function automatic logic [7:0] decoded_letter();
    string      code;
    int         len;
    logic [7:0] pat;
    if (sym_count > MAX_CODE_LEN) return CH_NUL;
    for (int i = 0; i < 36; i++) begin
      code = morse_code(i);
      len = code.len();
      pat = '0;
      for (int k = 0; k < len; k++) pat = {pat[6:0], code[k] == "-"};
      if (len == sym_count && pat == 8'(sym_bits)) begin
        if (i < 26) return upper_sel ? CH_UA + 8'(i) : CH_LA + 8'(i);
        if (i < 35) return CH_1 + 8'(i - 26);
        return CH_0;
      end
    end
    return CH_NUL;
  endfunction

  // Works out the characters that one accepted word should produce.
  task automatic predict_codec(logic [7:0] c, logic wl, logic ll);
    morse_out_t batch[$];
    int         idx;
    logic       word_done;
    string      code;
    word_done = wl | ll;
    idx = alnum_index(c);
    if (line_state == LINE_DROP) begin
      if (ll) line_state = WORD_IDLE;
      return;
    end
    if (line_state == WORD_IDLE) begin
      if (idx >= 0) line_state = WORD_ENCODE;
      else if (is_symbol(c)) line_state = WORD_DECODE;
    end
    if (line_state == WORD_ENCODE && idx >= 0) begin
      code = morse_code(idx);
      for (int k = 0; k < code.len(); k++) batch.push_back('{8'(code[k]), 1'b0, 1'b0});
      batch.push_back('{CH_SPACE, 1'b0, 1'b0});
      if (word_done) begin
        batch.push_back('{CH_SPACE, 1'b0, 1'b0});
        line_state = WORD_IDLE;
      end
    end else if (line_state == WORD_DECODE && is_symbol(c)) begin
      if (sym_count < MAX_CODE_LEN) begin
        sym_bits = {sym_bits[MAX_CODE_LEN-2:0], c == CH_DASH};
        sym_count = sym_count + 3'd1;
      end else begin
        sym_count = 3'(MAX_CODE_LEN + 1);
      end
      if (word_done) begin
        batch.push_back('{decoded_letter(), 1'b0, 1'b0});
        sym_count = '0;
        sym_bits = '0;
        line_state = WORD_IDLE;
      end
    end else begin
      // A class break reports once and drops the rest of the line.
      expected_chars.push_back('{CH_NUL, 1'b1, 1'b1});
      sym_count = '0;
      sym_bits = '0;
      line_state = ll ? WORD_IDLE : LINE_DROP;
      return;
    end
    if (ll) batch.push_back('{CH_NL, 1'b0, 1'b0});
    if (batch.size() > 0) batch[batch.size() - 1].last = 1'b1;
    foreach (batch[i]) expected_chars.push_back(batch[i]);
  endtask

  always @(posedge clk) begin : drive_chars
    logic go;
    go = 1'b0;
    if (!rst_n) begin
      in_valid <= 1'b0;
      line_state = WORD_IDLE;
      sym_count = '0;
      sym_bits = '0;
    end else begin
      if (in_valid && !in_stall) begin
        predict_codec(cur_char.ch, cur_char.word_end, cur_char.line_end);
        chars_taken++;
      end
      if (!in_valid || !in_stall) begin
        if (draining) begin
          if (expected_chars.size() == 0) draining = 1'b0;
        end else if (gap_left > 0) begin
          gap_left--;
        end else if (pending_chars.size() > 0) begin
          cur_char = pending_chars.pop_front();
          if (cur_char.drain) begin
            draining = 1'b1;
          end else begin
            go = 1'b1;
            in_char_in <= cur_char.ch;
            in_word_last <= cur_char.word_end;
            in_line_last <= cur_char.line_end;
            if (!calm && $urandom_range(0, 5) == 0) gap_left = $urandom_range(1, 5);
          end
        end
        in_valid <= go;
      end
    end
  end

  always @(posedge clk) begin : check_chars
    morse_out_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_chars.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result: char 0x%02h err %0b last %0b",
                     out_char_out, out_is_error, out_last);
        end else begin
          want = expected_chars.pop_front();
          if (out_char_out !== want.ch || out_is_error !== want.err ||
              out_last !== want.last) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: expected char 0x%02h err %0b last %0b, got 0x%02h %0b %0b",
                       want.ch, want.err, want.last, out_char_out, out_is_error, out_last);
          end
        end
      end
      if (stall_left > 0) stall_left--;
      else if (!calm && $urandom_range(0, 4) == 0) stall_left = $urandom_range(1, 5);
      out_stall <= (stall_left > 0) || (hold_left != 0);
    end
  end

  // Long receiver hold-off, counted here so the bursts above stay independent.
  always @(posedge clk) begin
    if (!rst_n) hold_left <= 0;
    else if (hold_arm) hold_left <= 100;
    else if (hold_left != 0) hold_left <= hold_left - 1;
  end

  task automatic queue_char(logic [7:0] c, logic wl, logic ll);
    pending_chars.push_back('{c, wl, ll, 1'b0});
  endtask

  // One line of words, occasionally broken by a character of the wrong class.
  task automatic queue_random_line(output int taken);
    int         nwords, bad_word, cut, ndrop, idx;
    bit         broken, encode, last_word;
    logic [7:0] word[$];
    logic [7:0] c;
    string      code;
    taken = 0;
    nwords = $urandom_range(1, 4);
    broken = ($urandom_range(0, 7) == 0);
    bad_word = $urandom_range(0, nwords - 1);
    for (int w = 0; w < nwords; w++) begin
      word.delete();
      encode = $urandom_range(0, 1);
      last_word = (w == nwords - 1);
      if (encode) begin
        repeat ($urandom_range(1, 4)) begin
          case ($urandom_range(0, 2))
            0: word.push_back(CH_UA + 8'($urandom_range(0, 25)));
            1: word.push_back(CH_LA + 8'($urandom_range(0, 25)));
            default: word.push_back(CH_0 + 8'($urandom_range(0, 9)));
          endcase
        end
      end else if ($urandom_range(0, 3) != 0) begin
        idx = $urandom_range(0, 35);
        code = morse_code(idx);
        for (int k = 0; k < code.len(); k++) word.push_back(8'(code[k]));
      end else begin
        repeat ($urandom_range(1, 7)) word.push_back($urandom_range(0, 1) ? CH_DASH : CH_DOT);
      end
      if (broken && w == bad_word) begin
        cut = $urandom_range(0, word.size() - 1);
        for (int k = 0; k < cut; k++) queue_char(word[k], 1'b0, 1'b0);
        if (cut > 0 && $urandom_range(0, 1)) begin
          c = encode ? ($urandom_range(0, 1) ? CH_DOT : CH_DASH)
                     : CH_LA + 8'($urandom_range(0, 25));
        end else begin
          do c = 8'($urandom_range(0, 255));
          while (alnum_index(c) >= 0 && (encode || cut == 0) ||
                 is_symbol(c) && (!encode || cut == 0));
        end
        ndrop = $urandom_range(0, 3);
        queue_char(c, 1'($urandom_range(0, 1)), ndrop == 0);
        taken += cut + 1;
        for (int d = 0; d < ndrop; d++)
          queue_char(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), d == ndrop - 1);
        return;
      end
      foreach (word[k]) begin
        if (k == word.size() - 1)
          queue_char(word[k], !last_word || $urandom_range(0, 1), last_word);
        else
          queue_char(word[k], 1'b0, 1'b0);
      end
      taken += word.size();
    end
  endtask

  task automatic queue_random_lines(int want);
    int got, n;
    got = 0;
    while (got < want) begin
      queue_random_line(n);
      got += n;
    end
  endtask

  task automatic wait_idle();
    while (pending_chars.size() != 0 || in_valid || draining || expected_chars.size() != 0) begin
      @(posedge clk);
      #1;
    end
    // Dropped characters make no result but may still be inside the block.
    repeat (12) @(posedge clk);
  endtask

  task automatic write_case(logic upper);
    wait_idle();
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_upper_case <= upper;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    upper_sel = upper;
  endtask

  initial begin
    int base;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Alphabet and digit extremes; the line ends without a word end.
    queue_char("a", 1'b0, 1'b0);
    queue_char("Z", 1'b1, 1'b0);
    queue_char("0", 1'b0, 1'b0);
    queue_char("9", 1'b0, 1'b1);
    // Decoding: a letter, the digit zero, an unknown code and an overlong run.
    queue_char(CH_DOT, 1'b0, 1'b0);
    queue_char(CH_DASH, 1'b1, 1'b0);
    repeat (4) queue_char(CH_DASH, 1'b0, 1'b0);
    queue_char(CH_DASH, 1'b1, 1'b0);
    queue_char(CH_DOT, 1'b0, 1'b0);
    queue_char(CH_DOT, 1'b0, 1'b0);
    queue_char(CH_DASH, 1'b0, 1'b0);
    queue_char(CH_DASH, 1'b1, 1'b0);
    repeat (5) queue_char(CH_DASH, 1'b0, 1'b0);
    queue_char(CH_DASH, 1'b0, 1'b1);
    // A mixed word, then characters that are dropped up to the line end.
    queue_char(CH_DOT, 1'b0, 1'b0);
    queue_char("x", 1'b0, 1'b0);
    queue_char(8'hFF, 1'b1, 1'b0);
    queue_char(8'h80, 1'b0, 1'b1);
    // A bad first character that also ends the line.
    queue_char(8'h00, 1'b1, 1'b1);

    write_case(1'b1);
    base = chars_taken;
    queue_random_lines(65);
    while (chars_taken < base + 12) @(posedge clk);
    hold_arm <= 1'b1;
    @(posedge clk);
    hold_arm <= 1'b0;

    write_case(1'b0);
    queue_random_lines(30);
    pending_chars.push_back('{8'h00, 1'b0, 1'b0, 1'b1});
    queue_random_lines(30);

    write_case(1'b1);
    calm <= 1'b1;
    queue_random_lines(65);

    wait_idle();
    if (mismatches == 0 && expected_chars.size() == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

endmodule
